// ===== rtl/gn3_pkg.sv =====
// Package with the shared types, constants and helper functions of the fbm gradient noise block.
`timescale 1ns / 1ps
package gn3_pkg;

	localparam int FRAC_BITS       = 16;
	localparam int DEF_MAX_OCTAVES = 8;
	localparam int GAIN_W          = 18;
	localparam int GAIN_FRAC       = 16;
	localparam int CNT_W           = 5;
	localparam int REG_CNT_W       = 4;
	localparam int OUT_W           = 24;
	localparam int TOT_W           = 40;
	localparam int G_W             = FRAC_BITS + 2;
	localparam int U_W             = FRAC_BITS + 1;
	localparam int V_W             = FRAC_BITS + 4;
	localparam int Q_W             = FRAC_BITS + 4;
	localparam int QF_W            = FRAC_BITS + 6;
	localparam int AMP_W           = FRAC_BITS + 13;
	localparam int DOT_W           = 2 * G_W + 2;
	localparam int HASH_W          = 28;

	localparam logic [AMP_W-1:0] AMP_ONE = AMP_W'(1) << FRAC_BITS;
	localparam logic [AMP_W-1:0] AMP_CAP = AMP_W'(1) << (FRAC_BITS + 12);

	localparam logic [31:0] HASH_SQ_MUL = 32'd15731;
	localparam logic [31:0] HASH_ADD    = 32'd789221;
	localparam logic [31:0] HASH_BIAS   = 32'd1376312589;

	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

	// Register index codes on the configuration port.
	localparam logic REG_OCTAVE_COUNT = 1'b0;
	localparam logic REG_OCTAVE_GAIN  = 1'b1;

	// Lattice hash coefficients, one row per gradient component.
	localparam logic [31:0] HASH_COEF [3][3] = '{
		'{32'd127, 32'd311, 32'd74},
		'{32'd269, 32'd183, 32'd246},
		'{32'd113, 32'd271, 32'd124}
	};

	// One transaction travelling down the chain of octave cells.
	typedef struct packed {
		logic                    valid;
		logic [31:0]             cx;
		logic [31:0]             cy;
		logic [31:0]             cz;
		logic signed [TOT_W-1:0] total;
		logic [AMP_W-1:0]        amp;
		logic [CNT_W-1:0]        count;
	} gn3_item_t;

	// Hash input contribution of the corner offset for corner j, component k.
	function automatic logic [31:0] corner_hash_off(input int j, input int k);
		logic [31:0] acc;
		acc = '0;
		for (int d = 0; d < 3; d++) begin
			if (((j >> d) & 1) != 0) begin
				acc = acc + HASH_COEF[k][d];
			end
		end
		return acc;
	endfunction

	// a + floor((b - a) * u / ONE).
	function automatic logic signed [V_W-1:0] lerp(
		input logic signed [V_W-1:0] a,
		input logic signed [V_W-1:0] b,
		input logic [U_W-1:0]        u
	);
		logic signed [V_W:0]         d;
		logic signed [V_W+U_W+1:0]   p;
		d = (V_W+1)'(b) - (V_W+1)'(a);
		p = d * $signed({1'b0, u});
		return a + V_W'(p >>> FRAC_BITS);
	endfunction

endpackage

// ===== rtl/gn3_hash.sv =====
// Three-stage pipelined corner hash that turns a mixed lattice sum into one gradient component.
`timescale 1ns / 1ps
module gn3_hash
	import gn3_pkg::*;
(
	input  logic                  clk,
	input  logic                  en,
	input  logic [31:0]           n,
	output logic signed [G_W-1:0] grad
);

	logic [31:0] n_s3, a_s3;
	logic [31:0] n_s4, b_s4;
	logic [31:0] h_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			n_s3 <= n;
			a_s3 <= n * n;
			n_s4 <= n_s3;
			b_s4 <= a_s3 * HASH_SQ_MUL + HASH_ADD;
			h_s5 <= n_s4 * b_s4 + HASH_BIAS;
		end
	end

	// The top bits of the 28-bit hash become a gradient in [-1, 1).
	assign grad = $signed({1'b0, h_s5[HASH_W-1:HASH_W-U_W]}) - $signed(G_W'(AMP_ONE));

endmodule

// ===== rtl/gn3_cell.sv =====
// One octave cell: twelve pipeline stages; adds one noise octave to the sum when IDX < count.
`timescale 1ns / 1ps
module gn3_cell
	import gn3_pkg::*;
#(
	parameter int IDX = 0
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              en,
	input  logic [GAIN_W-1:0] gain,
	input  gn3_item_t         item_in,
	output gn3_item_t         item_out
);

	localparam int LAST = 11;

	gn3_item_t item_s [1:LAST];

	logic [FRAC_BITS-1:0]       w_s   [1:5][3];
	logic [FRAC_BITS-1:0]       w2_s1 [3];
	logic [FRAC_BITS-1:0]       w3_s2 [3];
	logic [Q_W-1:0]             q_s2  [3];
	logic [U_W-1:0]             u_s   [3:9][3];
	logic [31:0]                base_s1 [3];
	logic [31:0]                n_s2  [8][3];
	logic [AMP_W+GAIN_W-1:0]    ampp_s1;
	logic [AMP_W-1:0]           ampn_s [2:LAST];
	logic signed [2*G_W-1:0]    prod_s6 [8][3];
	logic signed [V_W-1:0]      v_s7 [8];
	logic signed [V_W-1:0]      x_s8 [4];
	logic signed [V_W-1:0]      y_s9 [2];
	logic signed [V_W-1:0]      z_s10;
	logic signed [TOT_W-1:0]    term_s11;

	logic [FRAC_BITS-1:0]       w_in [3];
	logic [31:0]                lat  [3];
	logic [2*FRAC_BITS-1:0]     sq   [3];
	logic [2*FRAC_BITS-1:0]     cube [3];
	logic [QF_W-1:0]            qf   [3];
	logic [FRAC_BITS+Q_W-1:0]   fade [3];
	logic [31:0]                nsum [8][3];
	logic signed [G_W-1:0]      grad [8][3];
	logic signed [G_W-1:0]      off  [2][3];
	logic signed [DOT_W-1:0]    dot  [8];
	logic [AMP_W+GAIN_W-1-GAIN_FRAC:0] ampsh;
	logic signed [AMP_W+V_W:0]  tprod;
	logic                       active;

	always_comb begin
		w_in[0] = item_in.cx[FRAC_BITS-1:0];
		w_in[1] = item_in.cy[FRAC_BITS-1:0];
		w_in[2] = item_in.cz[FRAC_BITS-1:0];
		lat[0]  = {{FRAC_BITS{item_in.cx[31]}}, item_in.cx[31:FRAC_BITS]};
		lat[1]  = {{FRAC_BITS{item_in.cy[31]}}, item_in.cy[31:FRAC_BITS]};
		lat[2]  = {{FRAC_BITS{item_in.cz[31]}}, item_in.cz[31:FRAC_BITS]};
		for (int k = 0; k < 3; k++) begin
			sq[k]   = w_in[k] * w_in[k];
			cube[k] = w2_s1[k] * w_s[1][k];
			qf[k]   = QF_W'(6 * 32'(w2_s1[k])) + QF_W'(10 * 32'(AMP_ONE))
				- QF_W'(15 * 32'(w_s[1][k]));
			fade[k] = w3_s2[k] * q_s2[k];
			off[0][k] = $signed({2'b00, w_s[5][k]});
			off[1][k] = $signed({2'b00, w_s[5][k]}) - $signed(G_W'(AMP_ONE));
		end
		for (int j = 0; j < 8; j++) begin
			for (int k = 0; k < 3; k++) begin
				nsum[j][k] = base_s1[k] + corner_hash_off(j, k);
			end
			dot[j] = DOT_W'(prod_s6[j][0]) + DOT_W'(prod_s6[j][1]) + DOT_W'(prod_s6[j][2]);
		end
		ampsh  = ampp_s1[AMP_W+GAIN_W-1:GAIN_FRAC];
		tprod  = $signed({1'b0, item_s[10].amp}) * z_s10;
		active = (CNT_W+1)'(IDX) < (CNT_W+1)'(item_s[LAST].count);
	end

	for (genvar gj = 0; gj < 8; gj++) begin : g_corner
		for (genvar gk = 0; gk < 3; gk++) begin : g_comp
			gn3_hash u_hash (
				.clk  (clk),
				.en   (en),
				.n    (n_s2[gj][gk]),
				.grad (grad[gj][gk])
			);
		end
	end

	// Transaction shift line; only its valid bit needs a reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 1; s <= LAST; s++) begin
				item_s[s] <= '0;
			end
			item_out <= '0;
		end else if (en) begin
			item_s[1] <= item_in;
			for (int s = 2; s <= LAST; s++) begin
				item_s[s] <= item_s[s-1];
			end
			item_out.valid <= item_s[LAST].valid;
			item_out.cx    <= item_s[LAST].cx << 1;
			item_out.cy    <= item_s[LAST].cy << 1;
			item_out.cz    <= item_s[LAST].cz << 1;
			item_out.total <= item_s[LAST].total + (active ? term_s11 : '0);
			item_out.amp   <= ampn_s[LAST];
			item_out.count <= item_s[LAST].count;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// Stage 1: fraction squares, hash bases, amplitude product.
			for (int k = 0; k < 3; k++) begin
				w_s[1][k]  <= w_in[k];
				w2_s1[k]   <= sq[k][2*FRAC_BITS-1:FRAC_BITS];
				base_s1[k] <= lat[0] * HASH_COEF[k][0] + lat[1] * HASH_COEF[k][1]
					+ lat[2] * HASH_COEF[k][2];
			end
			ampp_s1 <= item_in.amp * gain;
			// Stage 2: cubes, quintic factor, per-corner hash inputs, amplitude cap.
			for (int k = 0; k < 3; k++) begin
				w3_s2[k] <= cube[k][2*FRAC_BITS-1:FRAC_BITS];
				q_s2[k]  <= qf[k][Q_W-1:0];
			end
			for (int j = 0; j < 8; j++) begin
				for (int k = 0; k < 3; k++) begin
					n_s2[j][k] <= (nsum[j][k] << 13) ^ nsum[j][k];
				end
			end
			ampn_s[2] <= (ampsh > ($bits(ampsh))'(AMP_CAP)) ? AMP_CAP : AMP_W'(ampsh);
			for (int s = 3; s <= LAST; s++) begin
				ampn_s[s] <= ampn_s[s-1];
			end
			for (int s = 2; s <= 5; s++) begin
				w_s[s] <= w_s[s-1];
			end
			// Stage 3: fade weights.
			for (int k = 0; k < 3; k++) begin
				u_s[3][k] <= fade[k][FRAC_BITS+U_W-1:FRAC_BITS];
			end
			for (int s = 4; s <= 9; s++) begin
				u_s[s] <= u_s[s-1];
			end
			// Stage 6: gradient times offset.
			for (int j = 0; j < 8; j++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s6[j][k] <= grad[j][k] * off[(j >> k) & 1][k];
				end
			end
			// Stage 7: corner values.
			for (int j = 0; j < 8; j++) begin
				v_s7[j] <= dot[j][V_W+FRAC_BITS-1:FRAC_BITS];
			end
			// Stages 8 to 10: blend along x, y and z.
			for (int i = 0; i < 4; i++) begin
				x_s8[i] <= lerp(v_s7[2*i], v_s7[2*i+1], u_s[7][0]);
			end
			for (int i = 0; i < 2; i++) begin
				y_s9[i] <= lerp(x_s8[2*i], x_s8[2*i+1], u_s[8][1]);
			end
			z_s10 <= lerp(y_s9[0], y_s9[1], u_s[9][2]);
			// Stage 11: amplitude-weighted term.
			term_s11 <= TOT_W'(tprod >>> FRAC_BITS);
		end
	end

endmodule

// ===== rtl/gradient_noise_3d_fbm.sv =====
// Top level of the fbm 3D gradient noise block: configuration registers, octave cell chain, output register.
`timescale 1ns / 1ps
// The block takes one point per clock while coord_stall is low and returns its fractal noise sum
// through the output register, in order, one result per point. The sum is formed by the chain of
// MAX_OCTAVES octave cells, each a twelve-stage pipeline (hash multiplies, fade, dot products,
// three blend levels, amplitude product and accumulate); every cell runs for every point, and a
// cell whose index is at or above the configured octave count passes the sum through unchanged.
// Throughput is one transaction per cycle unless stalled. When the output is stalled the result
// sits in the output register and the chain keeps accepting until a finished result reaches the last
// cell; only then is the input stalled. Registers octave_count (byte address 0) and octave_gain (byte
// address 4) are written over the APB port and must only be changed while the block is idle.
module gradient_noise_3d_fbm
	import gn3_pkg::*;
#(
	parameter int MAX_OCTAVES = DEF_MAX_OCTAVES
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    coord_valid,
	output logic                    coord_stall,
	input  logic signed [31:0]      coord_x,
	input  logic signed [31:0]      coord_y,
	input  logic signed [31:0]      coord_z,
	output logic                    noise_valid,
	input  logic                    noise_stall,
	output logic signed [OUT_W-1:0] noise_value,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);

	logic [REG_CNT_W-1:0] octave_count_q;
	logic [GAIN_W-1:0]    octave_gain_q;
	logic                 en;
	logic [CNT_W-1:0]     count_eff;
	gn3_item_t            chain [MAX_OCTAVES+1];
	logic signed [TOT_W-1:0] total;

	// Configuration port: always ready, writes complete in the access phase.
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octave_count_q <= REG_CNT_W'(1);
			octave_gain_q  <= GAIN_W'(32768);
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[2])
				REG_OCTAVE_COUNT: octave_count_q <= pwdata[REG_CNT_W-1:0];
				REG_OCTAVE_GAIN:  octave_gain_q  <= pwdata[GAIN_W-1:0];
				default:          ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_OCTAVE_COUNT: prdata = 32'(octave_count_q);
			REG_OCTAVE_GAIN:  prdata = 32'(octave_gain_q);
			default:          prdata = '0;
		endcase
	end

	// The whole chain advances together unless a finished result is blocked by a full,
	// stalled output register.
	assign en          = !(chain[MAX_OCTAVES].valid && noise_valid && noise_stall);
	assign coord_stall = !en;

	// Counts above the number of cells are clamped to the number of cells.
	assign count_eff = (CNT_W'(octave_count_q) > CNT_W'(MAX_OCTAVES)) ?
		CNT_W'(MAX_OCTAVES) : CNT_W'(octave_count_q);

	always_comb begin
		chain[0].valid = coord_valid;
		chain[0].cx    = coord_x;
		chain[0].cy    = coord_y;
		chain[0].cz    = coord_z;
		chain[0].total = '0;
		chain[0].amp   = AMP_ONE;
		chain[0].count = count_eff;
	end

	for (genvar gi = 0; gi < MAX_OCTAVES; gi++) begin : g_cell
		gn3_cell #(
			.IDX (gi)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (en),
			.gain     (octave_gain_q),
			.item_in  (chain[gi]),
			.item_out (chain[gi+1])
		);
	end

	assign total = chain[MAX_OCTAVES].total;

	// Output register with saturation of the accumulated sum.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			noise_valid <= 1'b0;
			noise_value <= '0;
		end else if (en && chain[MAX_OCTAVES].valid) begin
			noise_valid <= 1'b1;
			if (total > TOT_W'(OUT_MAX)) begin
				noise_value <= OUT_MAX;
			end else if (total < TOT_W'(OUT_MIN)) begin
				noise_value <= OUT_MIN;
			end else begin
				noise_value <= OUT_W'(total);
			end
		end else if (!noise_stall) begin
			noise_valid <= 1'b0;
		end
	end

endmodule

// ===== rtl/gn3_checker.sv =====
// Port-level checker for the fbm gradient noise block and its bind statement.
`timescale 1ns / 1ps
module gn3_checker
	import gn3_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        coord_stall,
	input logic        noise_valid,
	input logic        noise_stall,
	input logic        psel,
	input logic        penable,
	input logic        pwrite,
	input logic        pready,
	input logic [2:0]  paddr,
	input logic [31:0] pwdata,
	input logic [31:0] prdata
);

	// A result that is held off must stay offered.
	assert property (@(posedge clk) disable iff (!arst_n)
		(noise_valid && noise_stall) |=> noise_valid)
		else $error("result dropped while stalled");

	// The input is only held off when a result is waiting at a stalled output.
	assert property (@(posedge clk) disable iff (!arst_n)
		coord_stall |-> (noise_valid && noise_stall))
		else $error("input stalled without output back-pressure");

	// A written octave count reads back on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && $past(psel && penable && pwrite && pready)
			&& paddr == $past(paddr) && paddr[2] == REG_OCTAVE_COUNT)
		|-> prdata == 32'($past(pwdata[REG_CNT_W-1:0])))
		else $error("octave count readback mismatch");

	// A written gain reads back on the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		($past(arst_n) && $past(psel && penable && pwrite && pready)
			&& paddr == $past(paddr) && paddr[2] == REG_OCTAVE_GAIN)
		|-> prdata == 32'($past(pwdata[GAIN_W-1:0])))
		else $error("octave gain readback mismatch");

endmodule

bind gradient_noise_3d_fbm gn3_checker u_gn3_checker (.*);
